>>> rtl/hsuc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hsuc_pkg;

    // Conversion selectors
    localparam logic [3:0] MODE_TEMP_TO_CODE = 4'd0;
    localparam logic [3:0] MODE_CODE_TO_TEMP = 4'd1;
    localparam logic [3:0] MODE_VIN_TO_CODE  = 4'd2;
    localparam logic [3:0] MODE_CODE_TO_VIN  = 4'd3;
    localparam logic [3:0] MODE_VDD_TO_CODE  = 4'd4;
    localparam logic [3:0] MODE_CODE_TO_VDD  = 4'd5;
    localparam logic [3:0] MODE_RPM_TO_CODE  = 4'd6;
    localparam logic [3:0] MODE_CODE_TO_RPM  = 4'd7;
    localparam logic [3:0] MODE_VID          = 4'd8;
    localparam logic [3:0] MODE_DIV_TO_CODE  = 4'd9;

    // Divider geometry: 24-bit numerator, denominator and quotient
    localparam int DIV_W       = 24;
    localparam int DIV_STEPS   = 3;
    localparam int DIV_STAGES  = DIV_W / DIV_STEPS;
    localparam int PIPE_STAGES = DIV_STAGES + 2;

    // Clamped user value, wide enough for the rpm ceiling
    localparam int ARG_W = 21;

    localparam logic signed [31:0] TEMP_CLAMP   = 32'sd1400;
    localparam logic signed [31:0] VIN_CLAMP    = 32'sd600;
    localparam logic signed [31:0] VDD_CLAMP    = 32'sd700;
    localparam logic signed [31:0] RPM_CEIL     = 32'sd1000000;
    localparam logic [DIV_W-1:0]   FAN_CLOCK    = 24'd960000;
    localparam logic signed [15:0] TEMP_ZERO    = 16'sd130;
    localparam logic [4:0]         VID_OFF      = 5'h1f;
    localparam logic [4:0]         VID_HIGH     = 5'h10;

    typedef struct packed {
        logic [3:0]              mode;
        logic                    direct_en;
        logic [31:0]             direct;
        logic                    neg;
        logic signed [ARG_W-1:0] arg;
        logic [7:0]              code;
        logic [1:0]              dexp;
        logic [DIV_W-1:0]        nq;    // numerator in, quotient out
        logic [DIV_W-1:0]        rem;
        logic [DIV_W-1:0]        den;
    } t_stage;

    function automatic logic signed [31:0] clamp_s32(
        input logic signed [31:0] x,
        input logic signed [31:0] lo,
        input logic signed [31:0] hi
    );
        logic signed [31:0] r;
        r = x;
        if (x < lo) begin
            r = lo;
        end else if (x > hi) begin
            r = hi;
        end
        return r;
    endfunction

    // One restoring division step, quotient bit shifted into nq
    function automatic t_stage div_step(input t_stage s);
        t_stage        o;
        logic [DIV_W:0] rs;
        o  = s;
        rs = {s.rem, s.nq[DIV_W-1]};
        o.nq = {s.nq[DIV_W-2:0], 1'b0};
        if (rs >= {1'b0, s.den}) begin
            rs      = rs - {1'b0, s.den};
            o.nq[0] = 1'b1;
        end
        o.rem = rs[DIV_W-1:0];
        return o;
    endfunction

    function automatic t_stage div_steps(input t_stage s);
        t_stage o;
        o = s;
        for (int i = 0; i < DIV_STEPS; i++) begin
            o = div_step(o);
        end
        return o;
    endfunction

endpackage

`default_nettype wire

>>> rtl/hwmon_sensor_unit_converter.sv
`timescale 1ns / 1ps
`default_nettype none

// Hardware-monitor unit converter. Each transfer carries a mode, a signed
// 32-bit value and a fan divisor exponent, and yields one signed 32-bit
// result: a register code (clamped to its range) or a user-unit value
// (tenths of a degree, mV, rpm). Modes 10 to 15 give 0. The block is fully
// pipelined and takes one transfer per cycle while the output side is not
// stalled. A result passes through two set-up stages, then the shared
// 24-bit restoring divider, which retires three quotient bits in each of
// its eight stages, and then the output register. Back-pressure stalls
// only the stages that are full, so bubbles are squeezed out. The block
// keeps no state between items.
module hwmon_sensor_unit_converter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [3:0]  i_mode,
    input  wire logic [31:0] i_value,
    input  wire logic [1:0]  i_div_code,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_result
);
    import hsuc_pkg::*;

    localparam int LAST = PIPE_STAGES - 1;

    t_stage                 r_stg [PIPE_STAGES];
    t_stage                 n_stg [PIPE_STAGES];
    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES-1:0] en;
    logic                   en_out;
    logic                   r_out_valid;
    logic [31:0]            r_result;
    logic [31:0]            n_result;

    // Stage advance: a stage moves when it is empty or its successor moves
    always_comb begin
        en_out   = !r_out_valid || i_ready;
        en[LAST] = !r_vld[LAST] || en_out;
        for (int k = LAST - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_ready  = en[0];
    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    // Stage A: clamp the user value, pick out the code, form direct results
    always_comb begin
        logic signed [31:0] v;
        logic signed [31:0] c;
        logic signed [15:0] t16;
        logic [4:0]         vid;
        v   = $signed(i_value);
        c   = '0;
        t16 = '0;
        vid = i_value[4:0];
        n_stg[0]           = '0;
        n_stg[0].mode      = i_mode;
        n_stg[0].code      = i_value[7:0];
        n_stg[0].dexp      = i_div_code;
        n_stg[0].den       = DIV_W'(1);
        unique case (i_mode)
            MODE_TEMP_TO_CODE: begin
                c = clamp_s32(v, -TEMP_CLAMP, TEMP_CLAMP);
                n_stg[0].neg = v[31];
                n_stg[0].arg = c[ARG_W-1:0];
            end
            MODE_CODE_TO_TEMP: begin
                t16 = ($signed({8'b0, i_value[7:0]}) - TEMP_ZERO) * 16'sd10;
                n_stg[0].direct_en = 1'b1;
                n_stg[0].direct    = 32'(t16);
            end
            MODE_VIN_TO_CODE: begin
                c = clamp_s32(v, 32'sd0, VIN_CLAMP);
                n_stg[0].arg = c[ARG_W-1:0];
            end
            MODE_VDD_TO_CODE: begin
                c = clamp_s32(v, 32'sd0, VDD_CLAMP);
                n_stg[0].arg = c[ARG_W-1:0];
            end
            MODE_CODE_TO_VIN, MODE_CODE_TO_VDD: begin
            end
            MODE_RPM_TO_CODE: begin
                if (v == 32'sd0) begin
                    n_stg[0].direct_en = 1'b1;
                    n_stg[0].direct    = 32'd255;
                end else begin
                    c = clamp_s32(v, 32'sd1, RPM_CEIL);
                    n_stg[0].arg = c[ARG_W-1:0];
                end
            end
            MODE_CODE_TO_RPM: begin
                if (i_value[7:0] == 8'd0 || i_value[7:0] == 8'd255) begin
                    n_stg[0].direct_en = 1'b1;
                    n_stg[0].direct    = '0;
                end
            end
            MODE_VID: begin
                n_stg[0].direct_en = 1'b1;
                if (vid == VID_OFF) begin
                    n_stg[0].direct = '0;
                end else if (vid >= VID_HIGH) begin
                    n_stg[0].direct = 32'd510 - ({24'b0, vid, 3'b0} + {26'b0, vid, 1'b0});
                end else begin
                    n_stg[0].direct = 32'd205 - ({25'b0, vid, 2'b0} + {27'b0, vid});
                end
            end
            MODE_DIV_TO_CODE: begin
                n_stg[0].direct_en = 1'b1;
                priority if (v == 32'sd8) begin
                    n_stg[0].direct = 32'd3;
                end else if (v == 32'sd4) begin
                    n_stg[0].direct = 32'd2;
                end else if (v == 32'sd1) begin
                    n_stg[0].direct = 32'd0;
                end else begin
                    n_stg[0].direct = 32'd1;
                end
            end
            default: begin
                n_stg[0].direct_en = 1'b1;
                n_stg[0].direct    = '0;
            end
        endcase
    end

    // Stage B: numerator and denominator for the divider
    always_comb begin
        logic signed [ARG_W-1:0] a;
        logic [DIV_W-1:0]        t;
        a = r_stg[0].arg;
        t = {4'b0, a[19:0]} << r_stg[0].dexp;
        n_stg[1]     = r_stg[0];
        n_stg[1].rem = '0;
        n_stg[1].nq  = '0;
        n_stg[1].den = DIV_W'(1);
        unique case (r_stg[0].mode)
            MODE_TEMP_TO_CODE: begin
                if (r_stg[0].neg) begin
                    n_stg[1].nq = {3'b0, ARG_W'(21'sd5 - a)};
                end else begin
                    n_stg[1].nq = {3'b0, ARG_W'(a + 21'sd5)};
                end
                n_stg[1].den = DIV_W'(10);
            end
            MODE_VIN_TO_CODE: begin
                n_stg[1].nq  = {3'b0, ARG_W'(a * 21'sd10 + 21'sd8)};
                n_stg[1].den = DIV_W'(19);
            end
            MODE_VDD_TO_CODE: begin
                n_stg[1].nq  = {3'b0, ARG_W'(a * 21'sd10 + 21'sd11)};
                n_stg[1].den = DIV_W'(23);
            end
            MODE_CODE_TO_VIN: begin
                n_stg[1].nq  = {16'b0, r_stg[0].code} * DIV_W'(19);
                n_stg[1].den = DIV_W'(10);
            end
            MODE_CODE_TO_VDD: begin
                n_stg[1].nq  = {16'b0, r_stg[0].code} * DIV_W'(23);
                n_stg[1].den = DIV_W'(10);
            end
            MODE_RPM_TO_CODE: begin
                n_stg[1].nq  = FAN_CLOCK + (t >> 1);
                n_stg[1].den = t;
            end
            MODE_CODE_TO_RPM: begin
                n_stg[1].nq  = FAN_CLOCK;
                n_stg[1].den = {16'b0, r_stg[0].code} << r_stg[0].dexp;
            end
            default: begin
            end
        endcase
    end

    // Divider stages
    for (genvar g = 2; g < PIPE_STAGES; g++) begin : g_div
        always_comb begin
            n_stg[g] = div_steps(r_stg[g-1]);
        end
    end

    // Post-processing into the output register
    always_comb begin
        logic [DIV_W-1:0]   q;
        logic signed [10:0] qs;
        logic signed [10:0] sum;
        q   = r_stg[LAST].nq;
        qs  = r_stg[LAST].neg ? -$signed({2'b0, q[8:0]}) : $signed({2'b0, q[8:0]});
        sum = qs + 11'sd130;
        n_result = 32'(q);
        if (r_stg[LAST].direct_en) begin
            n_result = r_stg[LAST].direct;
        end else begin
            unique case (r_stg[LAST].mode)
                MODE_TEMP_TO_CODE: begin
                    priority if (sum < 11'sd0) begin
                        n_result = '0;
                    end else if (sum > 11'sd255) begin
                        n_result = 32'd255;
                    end else begin
                        n_result = {24'b0, sum[7:0]};
                    end
                end
                MODE_VIN_TO_CODE, MODE_VDD_TO_CODE: begin
                    n_result = (q > DIV_W'(255)) ? 32'd255 : 32'(q);
                end
                MODE_RPM_TO_CODE: begin
                    priority if (q < DIV_W'(1)) begin
                        n_result = 32'd1;
                    end else if (q > DIV_W'(254)) begin
                        n_result = 32'd254;
                    end else begin
                        n_result = 32'(q);
                    end
                end
                default: begin
                    n_result = 32'(q);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < PIPE_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (en_out) begin
                r_out_valid <= r_vld[LAST];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < PIPE_STAGES; k++) begin
            if (en[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
        if (en_out) begin
            r_result <= n_result;
        end
    end

    // Input is refused only when every stage and the output hold an item
    a_ready_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_vld && r_out_valid && !i_ready))
        else $error("input refused with room in pipeline");

    // Restoring divider keeps its partial remainder below the divisor
    a_rem_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAST] && r_stg[LAST].den != '0) |-> (r_stg[LAST].rem < r_stg[LAST].den))
        else $error("divider remainder out of range");

    // Reset empties the pipeline
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && r_vld == '0))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

>>> tb/hwmon_sensor_unit_converter_tb.sv
`timescale 1ns / 1ps

module hwmon_sensor_unit_converter_tb;
    import hsuc_pkg::*;

    // Mode codes the block leaves unused; both must read back 0
    localparam logic [3:0] MODE_SPARE_LO = 4'd10;
    localparam logic [3:0] MODE_SPARE_HI = 4'd15;

    // Conversion constants of the chip
    localparam longint FAN_REF_COUNT = 960000;
    localparam longint RPM_LIMIT     = 1000000;
    localparam longint TEMP_BIAS     = 130;
    localparam longint CODE_TOP      = 255;
    localparam longint FAN_CODE_TOP  = 254;
    localparam longint VID_OFF_CODE  = 'h1f;
    localparam longint VID_HIGH_CODE = 'h10;

    localparam int RANDOM_ITEMS = 1820;
    localparam int TAIL_ITEMS   = 200;    // last stretch runs with no idling
    localparam int HOLD_AFTER   = 900;    // transfers sent before the long output hold
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int NUM_PROBES   = 29;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic [3:0]  i_mode     = '0;
    logic [31:0] i_value    = '0;
    logic [1:0]  i_div_code = '0;
    logic        i_ready    = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_result;

    typedef struct {
        logic [3:0]  mode;
        logic [31:0] value;
        logic [1:0]  dexp;
        bit          typed;   // want holds a hand-worked result
        logic [31:0] want;
    } t_probe;

    typedef struct {
        int          seq;
        logic [3:0]  mode;
        logic [31:0] value;
        logic [1:0]  dexp;
        logic [31:0] result;
    } t_reading;

    // Directed transfers: clamp edges, rounding about zero, wide codes,
    // vid cut-off, divisor codes and the unused modes
    t_probe probes [NUM_PROBES] = '{
        '{MODE_TEMP_TO_CODE, 32'd0,         2'd0, 1'b1, 32'd130},
        '{MODE_TEMP_TO_CODE, 32'h8000_0000, 2'd0, 1'b1, 32'd0},
        '{MODE_TEMP_TO_CODE, 32'h7fff_ffff, 2'd0, 1'b1, 32'd255},
        '{MODE_TEMP_TO_CODE, -32'sd5,       2'd0, 1'b0, 32'd0},
        '{MODE_TEMP_TO_CODE, -32'sd4,       2'd0, 1'b0, 32'd0},
        '{MODE_CODE_TO_TEMP, 32'd0,         2'd0, 1'b1, -32'sd1300},
        '{MODE_CODE_TO_TEMP, 32'd255,       2'd0, 1'b1, 32'd1250},
        '{MODE_CODE_TO_TEMP, 32'habcd_ef82, 2'd0, 1'b0, 32'd0},
        '{MODE_VIN_TO_CODE,  32'h8000_0000, 2'd1, 1'b1, 32'd0},
        '{MODE_VIN_TO_CODE,  32'h7fff_ffff, 2'd2, 1'b1, 32'd255},
        '{MODE_CODE_TO_VIN,  32'd255,       2'd0, 1'b0, 32'd0},
        '{MODE_VDD_TO_CODE,  32'h8000_0000, 2'd0, 1'b1, 32'd0},
        '{MODE_VDD_TO_CODE,  32'h7fff_ffff, 2'd3, 1'b1, 32'd255},
        '{MODE_CODE_TO_VDD,  32'hffff_ffff, 2'd0, 1'b0, 32'd0},
        '{MODE_RPM_TO_CODE,  32'd0,         2'd3, 1'b1, 32'd255},
        '{MODE_RPM_TO_CODE,  32'd1,         2'd0, 1'b1, 32'd254},
        '{MODE_RPM_TO_CODE,  32'h8000_0000, 2'd2, 1'b1, 32'd254},
        '{MODE_RPM_TO_CODE,  32'h7fff_ffff, 2'd3, 1'b1, 32'd1},
        '{MODE_CODE_TO_RPM,  32'd0,         2'd1, 1'b1, 32'd0},
        '{MODE_CODE_TO_RPM,  32'hffff_ffff, 2'd0, 1'b1, 32'd0},
        '{MODE_CODE_TO_RPM,  32'd1,         2'd0, 1'b1, 32'd960000},
        '{MODE_CODE_TO_RPM,  32'd254,       2'd3, 1'b0, 32'd0},
        '{MODE_VID,          32'h0000_001f, 2'd0, 1'b1, 32'd0},
        '{MODE_VID,          32'hffff_ffe0, 2'd0, 1'b0, 32'd0},
        '{MODE_DIV_TO_CODE,  32'd8,         2'd0, 1'b1, 32'd3},
        '{MODE_DIV_TO_CODE,  32'd4,         2'd0, 1'b1, 32'd2},
        '{MODE_DIV_TO_CODE,  32'd1,         2'd0, 1'b1, 32'd0},
        '{MODE_SPARE_LO,     32'h7fff_ffff, 2'd3, 1'b1, 32'd0},
        '{MODE_SPARE_HI,     32'h8000_0000, 2'd1, 1'b1, 32'd0}
    };

    t_reading pending_readings [$];
    int       errors       = 0;
    int       sent         = 0;
    int       checked      = 0;
    int       cycle_count  = 0;
    int       input_stalls = 0;
    int       send_rate    = 0;
    bit       tail_phase   = 1'b0;
    int       mode_hits [16];

    hwmon_sensor_unit_converter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_mode     (i_mode),
        .i_value    (i_value),
        .i_div_code (i_div_code),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (o_result)
    );

    always #5 i_clk = ~i_clk;

    // Cycle count, back-pressure count and the overall time limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && i_valid && !o_ready) begin
            input_stalls <= input_stalls + 1;
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("hwmon_sensor_unit_converter_tb: errors");
            $finish;
        end
    end

    function automatic longint clamp_range(longint x, longint lo, longint hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    // Expected result of one conversion. Everything is worked at 64 bits,
    // so nothing wraps before the final truncation to 32 bits; division
    // on longint truncates toward zero.
    function automatic logic [31:0] unit_convert(logic [3:0] mode,
                                                 logic signed [31:0] value,
                                                 logic [1:0] dexp);
        longint v;
        longint code;
        longint d;
        longint t;
        longint r;
        v    = value;
        code = longint'(value[7:0]);
        d    = longint'(1) << dexp;
        case (mode)
            MODE_TEMP_TO_CODE: begin
                t = (v < 0) ? v - 5 : v + 5;
                r = clamp_range(t / 10 + TEMP_BIAS, 0, CODE_TOP);
            end
            MODE_CODE_TO_TEMP: r = (code - TEMP_BIAS) * 10;
            MODE_VIN_TO_CODE:  r = clamp_range((v * 10 + 8) / 19, 0, CODE_TOP);
            MODE_CODE_TO_VIN:  r = (code * 19) / 10;
            MODE_VDD_TO_CODE:  r = clamp_range((v * 10 + 11) / 23, 0, CODE_TOP);
            MODE_CODE_TO_VDD:  r = (code * 23) / 10;
            MODE_RPM_TO_CODE: begin
                if (v == 0) begin
                    r = CODE_TOP;
                end else begin
                    t = clamp_range(v, 1, RPM_LIMIT) * d;
                    r = clamp_range((FAN_REF_COUNT + t / 2) / t, 1, FAN_CODE_TOP);
                end
            end
            MODE_CODE_TO_RPM: begin
                if (code == 0 || code == CODE_TOP) r = 0;
                else r = FAN_REF_COUNT / (code * d);
            end
            MODE_VID: begin
                t = longint'(value[4:0]);
                if (t == VID_OFF_CODE) r = 0;
                else if (t >= VID_HIGH_CODE) r = 510 - t * 10;
                else r = 205 - t * 5;
            end
            MODE_DIV_TO_CODE: begin
                if (v == 8) r = 3;
                else if (v == 4) r = 2;
                else if (v == 1) r = 0;
                else r = 1;
            end
            default: r = 0;
        endcase
        return r[31:0];
    endfunction

    // Random value for a mode: mostly within the mode's useful span, with
    // raw 32-bit noise and the signed extremes mixed in
    function automatic logic [31:0] pick_value(logic [3:0] mode);
        logic [31:0] v;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 2) return $urandom;
        if (sel == 2) begin
            case ($urandom_range(0, 4))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7fff_ffff;
                2:       v = '0;
                3:       v = '1;
                default: v = 32'd1;
            endcase
            return v;
        end
        case (mode)
            MODE_TEMP_TO_CODE: v = $urandom_range(0, 3200) - 32'd1600;
            MODE_VIN_TO_CODE,
            MODE_VDD_TO_CODE:  v = $urandom_range(0, 900) - 32'd100;
            MODE_RPM_TO_CODE: begin
                if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 2000000);
                else v = $urandom_range(0, 20000);
            end
            MODE_VID: begin
                v = $urandom_range(0, 31);
                if ($urandom_range(0, 1)) v = v | ($urandom & 32'hffff_ffe0);
            end
            MODE_DIV_TO_CODE: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'd1;
                    1:       v = 32'd2;
                    2:       v = 32'd4;
                    3:       v = 32'd8;
                    default: v = $urandom_range(0, 16);
                endcase
            end
            default: begin
                // from-code modes: a byte, sometimes with junk above it
                v = $urandom_range(0, 255);
                if ($urandom_range(0, 1)) v = v | ($urandom & 32'hffff_ff00);
            end
        endcase
        return v;
    endfunction

    // Offer one transfer, idling first if the current rate says so, and log
    // its expected result once it is taken
    task automatic offer(input logic [3:0] mode, input logic [31:0] value,
                         input logic [1:0] dexp, input bit typed,
                         input logic [31:0] want);
        t_reading r;
        if (!tail_phase && send_rate != 0 && $urandom_range(1, 100) <= send_rate) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_mode     <= mode;
        i_value    <= value;
        i_div_code <= dexp;
        do @(posedge i_clk); while (!o_ready);
        r.seq    = sent;
        r.mode   = mode;
        r.value  = value;
        r.dexp   = dexp;
        r.result = typed ? want : unit_convert(mode, value, dexp);
        pending_readings.push_back(r);
        sent++;
        mode_hits[mode]++;
    endtask

    // Result side: checks each transfer against the oldest expectation and
    // drives ready with random stall bursts, one long hold and a quiet tail
    initial begin
        int stall_left;
        int hold_left;
        int ready_rate;
        bit hold_done;
        t_reading r;
        stall_left = 0;
        hold_left  = 0;
        ready_rate = 0;
        hold_done  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (o_valid && i_ready) begin
                    if (pending_readings.size() == 0) begin
                        $error("result: expected nothing, actual %0d", $signed(o_result));
                        errors++;
                    end else begin
                        r = pending_readings.pop_front();
                        checked++;
                        if (o_result !== r.result) begin
                            $error("result (transfer %0d, mode %0d, value %0d, div %0d): expected %0d, actual %0d",
                                   r.seq, r.mode, $signed(r.value), r.dexp,
                                   $signed(r.result), $signed(o_result));
                            errors++;
                        end
                    end
                end
                if (!hold_done && sent >= HOLD_AFTER) begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
                if (cycle_count % 256 == 0) begin
                    case ($urandom_range(0, 3))
                        0, 1:    ready_rate = 0;
                        2:       ready_rate = 10;
                        default: ready_rate = 35;
                    endcase
                end
                if (hold_left > 0) begin
                    hold_left--;
                    i_ready <= 1'b0;
                end else if (stall_left > 0) begin
                    stall_left--;
                    i_ready <= 1'b0;
                end else if (!tail_phase && ready_rate != 0 &&
                             $urandom_range(1, 100) <= ready_rate) begin
                    stall_left = $urandom_range(1, 18) - 1;
                    i_ready <= 1'b0;
                end else begin
                    i_ready <= 1'b1;
                end
            end
        end
    end

    // Input side: reset, directed table, then random transfers
    initial begin
        logic [3:0] mode;
        int         modes_seen;
        foreach (mode_hits[k]) mode_hits[k] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (probes[k]) begin
            offer(probes[k].mode, probes[k].value, probes[k].dexp,
                  probes[k].typed, probes[k].want);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 128 == 0) begin
                case ($urandom_range(0, 3))
                    0, 1:    send_rate = 0;
                    2:       send_rate = 10;
                    default: send_rate = 30;
                endcase
            end
            if (n >= RANDOM_ITEMS - TAIL_ITEMS) tail_phase = 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                mode = $urandom_range(MODE_SPARE_LO, MODE_SPARE_HI);
            end else begin
                mode = $urandom_range(MODE_TEMP_TO_CODE, MODE_DIV_TO_CODE);
            end
            offer(mode, pick_value(mode), $urandom_range(0, 3), 1'b0, '0);
        end
        i_valid <= 1'b0;

        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        modes_seen = 0;
        foreach (mode_hits[k]) if (mode_hits[k] != 0) modes_seen++;
        $display("%0d conversions checked (%0d directed), %0d of 16 mode codes exercised",
                 checked, NUM_PROBES, modes_seen);
        $display("input stalled by back-pressure for %0d cycles; %0d cycles in all",
                 input_stalls, cycle_count);
        if (errors == 0) begin
            $display("hwmon_sensor_unit_converter_tb: clean");
        end else begin
            $display("hwmon_sensor_unit_converter_tb: errors");
        end
        $finish;
    end

endmodule
